// File: sv/erg_pkg.sv
// erg_pkg: shared types, constants and helpers of the endpoint registry table
// used by the design modules and interfaces of the block; no dependencies

package erg_pkg;

  localparam int ENTRIES     = 64;
  localparam int IDXW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW        = $clog2(ENTRIES + 1);
  localparam int MAX_RESULTS = 64;
  localparam int MCW         = $clog2(MAX_RESULTS + 1);
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [2:0] OP_ANNOUNCE  = 3'd0;
  localparam logic [2:0] OP_WITHDRAW  = 3'd1;
  localparam logic [2:0] OP_WDRAW_ALL = 3'd2;
  localparam logic [2:0] OP_HEARTBEAT = 3'd3;
  localparam logic [2:0] OP_LOOKUP    = 3'd4;
  localparam logic [2:0] OP_COLLECT   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] owner_id;
    logic [7:0]  domain;
    logic [63:0] topic_hash;
    logic [63:0] type_hash_in;
    logic [1:0]  role_in;
    logic [5:0]  slot_in;
    logic [63:0] now_ns;
    logic [31:0] stale_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [31:0] owner_out;
    logic [7:0]  domain_out;
    logic [63:0] type_hash_out;
    logic [1:0]  role_out;
    logic [6:0]  freed_count;
    logic [63:0] generation_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] owner;
    logic [7:0]  domain;
    logic [63:0] topic_hash;
    logic [63:0] ty_hash;
    logic [1:0]  role;
    logic [63:0] heartbeat;
  } entry_t;

  // per-slot verdict from the head unit
  typedef struct packed {
    logic claim;
    logic owner_hit;
    logic match;
    logic freed;
  } verdict_t;

  function automatic logic [5:0] slot6(input logic [IDXW-1:0] idx);
    logic [IDXW+5:0] w;
    w = {6'd0, idx};
    return w[5:0];
  endfunction

  function automatic logic [6:0] sat7(input logic [CNTW-1:0] n);
    logic [CNTW+6:0] w;
    w = {7'd0, n};
    return (w > (CNTW+7)'(127)) ? 7'd127 : w[6:0];
  endfunction

endpackage

// File: sv/erg_if.sv
// erg_if: valid/ready channel interfaces for input and result items
// depends on erg_pkg

interface erg_in_if;
  logic             valid;
  logic             ready;
  erg_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface erg_out_if;
  logic              valid;
  logic              ready;
  erg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/erg_cell.sv
// erg_cell: one slot of the rotating entry ring
// depends on erg_pkg

module erg_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  erg_pkg::entry_t d,
  output erg_pkg::entry_t q
);

  logic        valid_r;
  logic [31:0] owner_r;
  logic [7:0]  domain_r;
  logic [63:0] topic_r;
  logic [63:0] ty_r;
  logic [1:0]  role_r;
  logic [63:0] beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      owner_r  <= d.owner;
      domain_r <= d.domain;
      topic_r  <= d.topic_hash;
      ty_r     <= d.ty_hash;
      role_r   <= d.role;
      beat_r   <= d.heartbeat;
    end
  end

  assign q = {valid_r, owner_r, domain_r, topic_r, ty_r, role_r, beat_r};

endmodule

// File: sv/erg_unit.sv
// erg_unit: applies the current operation to the entry at the head of the ring
// depends on erg_pkg

module erg_unit (
  input  erg_pkg::in_item_t        cmd,
  input  logic [63:0]              thr,
  input  logic [erg_pkg::IDXW-1:0] idx,
  input  logic                     found,
  input  erg_pkg::entry_t          head,
  output erg_pkg::entry_t          wb,
  output erg_pkg::verdict_t        vd
);

  logic owner_eq;
  logic lk_match;
  logic stale;
  logic [63:0] age;

  assign owner_eq = head.valid && (head.owner == cmd.owner_id);
  assign lk_match = head.valid && (head.topic_hash == cmd.topic_hash) &&
                    (head.role == cmd.role_in) &&
                    ((cmd.type_hash_in == 64'd0) || (head.ty_hash == cmd.type_hash_in));
  assign age   = cmd.now_ns - head.heartbeat;
  assign stale = head.valid && (cmd.now_ns > head.heartbeat) && (age > thr);

  always_comb begin
    wb = head;
    vd = '0;
    unique case (cmd.op)
      erg_pkg::OP_ANNOUNCE: begin
        if (!found && !head.valid) begin
          vd.claim        = 1'b1;
          wb.valid        = 1'b1;
          wb.owner        = cmd.owner_id;
          wb.domain       = cmd.domain;
          wb.topic_hash   = cmd.topic_hash;
          wb.ty_hash      = cmd.type_hash_in;
          wb.role         = cmd.role_in;
          wb.heartbeat    = cmd.now_ns;
        end
      end
      erg_pkg::OP_WITHDRAW: begin
        if ({6'd0, idx} == {{erg_pkg::IDXW{1'b0}}, cmd.slot_in}) begin
          wb.valid = 1'b0;
        end
      end
      erg_pkg::OP_WDRAW_ALL: begin
        if (owner_eq) begin
          vd.owner_hit = 1'b1;
          wb.valid     = 1'b0;
        end
      end
      erg_pkg::OP_HEARTBEAT: begin
        if (owner_eq) begin
          vd.owner_hit = 1'b1;
          wb.heartbeat = cmd.now_ns;
        end
      end
      erg_pkg::OP_LOOKUP: begin
        vd.match = lk_match;
      end
      erg_pkg::OP_COLLECT: begin
        if (stale) begin
          vd.freed = 1'b1;
          wb.valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/endpoint_registry_table.sv
// endpoint_registry_table: top level, entry ring, scan sequencer and result register
// depends on erg_pkg, erg_if, erg_cell, erg_unit

// usage
//   in_ch carries one operation per item (announce, withdraw, withdraw all,
//   heartbeat, lookup, collect stale); out_ch returns result items, the final
//   one of each operation flagged by last
//   entries sit in a ring of cells; every scan cycle in which the result
//   register can load, the ring turns by one and the head entry passes
//   through a single update unit, so one full turn visits every slot in
//   order and leaves the ring as it was; the final item of an operation is
//   presented from the result register after the scan of all ENTRIES slots
//   and the finish state that follows; one operation is scanned at a time,
//   in_ch.ready is high only when the sequencer is idle
//   lookup emits each match as it is found, one item behind, so the last
//   match can be flagged; other operations give one item at the finish
//   a stalled receiver freezes the ring and the sequencer; the result register
//   holds its item until taken, and the next operation may be accepted
//   meanwhile but does not scan until that item is gone
//   reset (synchronous, active low) frees every slot and clears the change
//   counter; entry contents are left as they were

module endpoint_registry_table (
  input  logic             clk,
  input  logic             rst_n,
  erg_in_if.sink           in_ch,
  erg_out_if.source        out_ch
);

  localparam int E    = erg_pkg::ENTRIES;
  localparam int IDXW = erg_pkg::IDXW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // operation held for the whole scan
  erg_pkg::in_item_t cmd_r;
  logic [63:0]       thr_r;

  logic [IDXW-1:0]          cnt_r, cnt_nxt;
  logic                     found_r, found_nxt;
  logic [IDXW-1:0]          fslot_r, fslot_nxt;
  logic                     hit_r, hit_nxt;
  logic [erg_pkg::CNTW-1:0] freed_r, freed_nxt;
  logic [erg_pkg::MCW-1:0]  mcnt_r, mcnt_nxt;
  logic [63:0]              gen_r, gen_nxt;

  // lookup match waiting for its last flag
  erg_pkg::out_item_t pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;

  erg_pkg::out_item_t out_r, out_nxt;
  logic               out_v_r, out_v_nxt;

  logic can_load;
  logic step;

  erg_pkg::entry_t   ring_q [E];
  erg_pkg::entry_t   ring_d [E];
  erg_pkg::entry_t   wb;
  erg_pkg::verdict_t vd;

  logic        in_range;
  logic        changed;
  logic [61:0] thr_prod;

  assign can_load = !out_v_r || out_ch.ready;
  assign step     = (state_r == S_SCAN) && can_load;

  // ring: each cell takes its neighbor's entry, the tail takes the update
  for (genvar i = 0; i < E; i++) begin : g_ring
    if (i == E - 1) begin : g_tail
      assign ring_d[i] = wb;
    end else begin : g_mid
      assign ring_d[i] = ring_q[i+1];
    end
    erg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (step),
      .d        (ring_d[i]),
      .q        (ring_q[i])
    );
  end

  erg_unit u_unit (
    .cmd   (cmd_r),
    .thr   (thr_r),
    .idx   (cnt_r),
    .found (found_r),
    .head  (ring_q[0]),
    .wb    (wb),
    .vd    (vd)
  );

  // age limit in ns, registered straight off the input
  assign thr_prod = in_ch.data.stale_seconds * erg_pkg::NS_PER_SEC;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r <= in_ch.data;
      thr_r <= {2'b00, thr_prod};
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  assign in_range = ({5'd0, cmd_r.slot_in} < 11'(E));

  always_comb begin
    unique case (cmd_r.op)
      erg_pkg::OP_ANNOUNCE:  changed = found_r;
      erg_pkg::OP_WITHDRAW:  changed = in_range;
      erg_pkg::OP_WDRAW_ALL: changed = hit_r;
      erg_pkg::OP_COLLECT:   changed = (freed_r != '0);
      default:               changed = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    fslot_nxt  = fslot_r;
    hit_nxt    = hit_r;
    freed_nxt  = freed_r;
    mcnt_nxt   = mcnt_r;
    gen_nxt    = gen_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt  = S_SCAN;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          hit_nxt    = 1'b0;
          freed_nxt  = '0;
          mcnt_nxt   = '0;
          pend_v_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (can_load) begin
          if (vd.claim) begin
            found_nxt = 1'b1;
            fslot_nxt = cnt_r;
          end
          if (vd.owner_hit) begin
            hit_nxt = 1'b1;
          end
          if (vd.freed) begin
            freed_nxt = freed_r + 1'b1;
          end
          if (vd.match && (mcnt_r < erg_pkg::MCW'(erg_pkg::MAX_RESULTS))) begin
            // flush the previous match, keep this one back
            if (pend_v_r) begin
              out_nxt   = pend_r;
              out_v_nxt = 1'b1;
            end
            pend_nxt                = '0;
            pend_nxt.status         = erg_pkg::ST_OK;
            pend_nxt.slot_out       = erg_pkg::slot6(cnt_r);
            pend_nxt.owner_out      = ring_q[0].owner;
            pend_nxt.domain_out     = ring_q[0].domain;
            pend_nxt.type_hash_out  = ring_q[0].ty_hash;
            pend_nxt.role_out       = ring_q[0].role;
            pend_nxt.generation_out = gen_r;
            pend_v_nxt              = 1'b1;
            mcnt_nxt                = mcnt_r + 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == IDXW'(E - 1)) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (can_load) begin
          gen_nxt                = gen_r + {63'd0, changed};
          out_nxt                = '0;
          out_nxt.generation_out = gen_r + {63'd0, changed};
          out_nxt.last           = 1'b1;
          out_v_nxt              = 1'b1;
          state_nxt              = S_IDLE;
          unique case (cmd_r.op) inside
            erg_pkg::OP_ANNOUNCE: begin
              out_nxt.status   = found_r ? erg_pkg::ST_OK : erg_pkg::ST_FULL;
              out_nxt.slot_out = found_r ? erg_pkg::slot6(fslot_r) : 6'd0;
            end
            erg_pkg::OP_WITHDRAW: begin
              out_nxt.status = in_range ? erg_pkg::ST_OK : erg_pkg::ST_NOMATCH;
            end
            erg_pkg::OP_WDRAW_ALL, erg_pkg::OP_HEARTBEAT: begin
              out_nxt.status = hit_r ? erg_pkg::ST_OK : erg_pkg::ST_NOMATCH;
            end
            erg_pkg::OP_LOOKUP: begin
              if (pend_v_r) begin
                out_nxt      = pend_r;
                out_nxt.last = 1'b1;
              end else begin
                out_nxt.status = erg_pkg::ST_NOMATCH;
              end
            end
            erg_pkg::OP_COLLECT: begin
              out_nxt.status      = erg_pkg::ST_OK;
              out_nxt.freed_count = erg_pkg::sat7(freed_r);
            end
            default: begin
              out_nxt.status = erg_pkg::ST_NOMATCH;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      gen_r    <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      found_r  <= 1'b0;
      hit_r    <= 1'b0;
      freed_r  <= '0;
      mcnt_r   <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      gen_r    <= gen_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
      found_r  <= found_nxt;
      hit_r    <= hit_nxt;
      freed_r  <= freed_nxt;
      mcnt_r   <= mcnt_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fslot_r <= fslot_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

// File: sv/erg_chk.sv
// erg_chk: port-level checks of the endpoint registry table, bound to the top
// depends on endpoint_registry_table

module erg_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [1:0] out_status
);

  logic       acc;
  logic       done;
  logic [1:0] open_r;

  assign acc  = in_valid && in_ready;
  assign done = out_valid && out_ready && out_last;

  // operations accepted whose last item has not yet been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 2'd0;
    end else if (acc && !done) begin
      open_r <= open_r + 2'd1;
    end else if (!acc && done) begin
      open_r <= open_r - 2'd1;
    end
  end

  // a new operation starts only once the previous one has its last item out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ((open_r == 2'd0) || (out_valid && out_last)))
    else $error("item accepted while an operation is open");

  // results only belong to an open operation
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> (open_r != 2'd0))
    else $error("result item without an open operation");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_last) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind endpoint_registry_table erg_chk u_erg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_last   (out_ch.data.last),
  .out_status (out_ch.data.status)
);
